>>> rtl/asc32_pkg.sv
// ----------------------------------------------------------------------------
// asc32_pkg: shared types and constants for the combined arithmetic shift
// Word widths, count width and the request/response word layouts.
// ----------------------------------------------------------------------------
package asc32_pkg;

   localparam int WORD_W  = 16;
   localparam int PAIR_W  = 2 * WORD_W;
   localparam int COUNT_W = 6;

   // one request word: register pair, signed count, odd-register marker
   typedef struct packed {
      logic [WORD_W-1:0]  high_word;
      logic [WORD_W-1:0]  low_word;
      logic [COUNT_W-1:0] shift_operand;
      logic               odd_register;
   } asc32_req_type;

   // one response word: shifted words, pair write strobe and N/Z/V/C
   typedef struct packed {
      logic [WORD_W-1:0] high_result;
      logic [WORD_W-1:0] low_result;
      logic              write_pair;
      logic              negative_flag;
      logic              zero_flag;
      logic              overflow_flag;
      logic              carry_flag;
   } asc32_rsp_type;

endpackage

>>> rtl/arith_shift_combined_32_unit.sv
// ----------------------------------------------------------------------------
// arith_shift_combined_32_unit: combined arithmetic shift of a register pair
// Registered request, one-pass shifter and flags, registered response.
// ----------------------------------------------------------------------------
// Takes one request word per clock and returns one response word for each,
// in order. A word passes through the input register and then the result
// register, with the shift and flag logic between them. Throughput is one
// word per cycle for as long as the response side keeps taking words; a
// stalled response backs up through the two registers, and the input side
// keeps accepting until both hold.
// ----------------------------------------------------------------------------
module arith_shift_combined_32_unit import asc32_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  asc32_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output asc32_rsp_type rsp_data
);

   logic          req_valid_ff;
   logic          req_valid_in;
   asc32_req_type req_data_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   asc32_rsp_type rsp_data_ff;
   asc32_rsp_type rsp_calc;
   logic          rsp_load;
   logic          req_load;

   // advance the result stage when it is empty or being drained
   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   assign req_load  = !req_valid_ff || rsp_load;
   assign req_ready = req_load;

   assign req_valid_in = req_load ? req_valid : req_valid_ff;
   assign rsp_valid_in = rsp_load ? req_valid_ff : rsp_valid_ff;

   // shift and flag datapath
   asc32_shifter u_shifter (
      .req (req_data_ff),
      .rsp (rsp_calc)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: hold while stalled
   always_ff @(posedge clock) begin
      if (req_load) begin
         req_data_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_calc;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/asc32_shifter.sv
// ----------------------------------------------------------------------------
// asc32_shifter: combined 32-bit arithmetic shift with condition flags
// Pure combinational datapath between the input and result registers.
// ----------------------------------------------------------------------------
module asc32_shifter import asc32_pkg::*; (
   input  asc32_req_type req,
   output asc32_rsp_type rsp
);

   logic [PAIR_W-1:0]  val;
   logic               sign;
   logic               cnt_zero;
   logic               left;
   logic [COUNT_W-1:0] right_n;
   logic [PAIR_W:0]    left_ext;
   logic [PAIR_W:0]    right_ext;
   logic [PAIR_W-1:0]  res;
   logic               carry;
   logic               ovf;

   assign val      = {req.high_word, req.low_word};
   assign sign     = val[PAIR_W-1];
   assign cnt_zero = (req.shift_operand == '0);
   assign left     = !cnt_zero && !req.shift_operand[COUNT_W-1];

   // magnitude of a negative count, 1..32
   assign right_n  = COUNT_W'(-req.shift_operand);

   // left: extra bit on top catches the last bit shifted out
   assign left_ext  = {1'b0, val} << req.shift_operand[COUNT_W-2:0];

   // right: extra bit below catches the last bit shifted out, sign fills top
   assign right_ext = $unsigned($signed({val, 1'b0}) >>> right_n);

   // select shift direction
   always_comb begin
      res   = val;
      carry = 1'b0;
      ovf   = 1'b0;
      if (left) begin
         res   = left_ext[PAIR_W-1:0];
         carry = left_ext[PAIR_W];
         ovf   = sign ^ left_ext[PAIR_W-1];
      end else if (!cnt_zero) begin
         res   = right_ext[PAIR_W:1];
         carry = right_ext[0];
      end
   end

   // pack flags; odd register writes only the low word
   always_comb begin
      rsp.low_result    = res[WORD_W-1:0];
      rsp.overflow_flag = ovf;
      if (req.odd_register) begin
         rsp.high_result   = '0;
         rsp.write_pair    = 1'b0;
         rsp.negative_flag = res[WORD_W-1];
         rsp.zero_flag     = (res[WORD_W-1:0] == '0);
         rsp.carry_flag    = 1'b0;
      end else begin
         rsp.high_result   = res[PAIR_W-1:WORD_W];
         rsp.write_pair    = 1'b1;
         rsp.negative_flag = res[PAIR_W-1];
         rsp.zero_flag     = (res == '0);
         rsp.carry_flag    = carry;
      end
   end

endmodule

>>> rtl/asc32_checker.sv
// ----------------------------------------------------------------------------
// asc32_checker: port-level checks for the combined arithmetic shift unit
// Watches the response channel and the flag coding of each response word.
// ----------------------------------------------------------------------------
module asc32_checker import asc32_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_ready,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input asc32_rsp_type rsp_data
);

   // hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // no response word right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // odd register: high word and carry cleared, N from low word
   a_odd_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.write_pair |->
         rsp_data.high_result == '0 && !rsp_data.carry_flag &&
         rsp_data.negative_flag == rsp_data.low_result[WORD_W-1])
      else $error("odd register response malformed");

   // pair write: N and Z follow the 32-bit result
   a_pair_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.write_pair |->
         rsp_data.negative_flag == rsp_data.high_result[WORD_W-1] &&
         rsp_data.zero_flag == (rsp_data.high_result == '0 &&
                                rsp_data.low_result == '0))
      else $error("pair response flags inconsistent");

   // a word accepted into an empty block shows up once it has passed the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid ##1 !rsp_valid |=> rsp_valid)
      else $error("response word missing");

endmodule

bind arith_shift_combined_32_unit asc32_checker u_asc32_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
